// ----- hdl/cca_pkg.sv -----
package cca_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int AMT_W      = 21;
    localparam int ZONE_W     = 5;
    localparam int CMD_W      = 3;
    localparam int WDAY_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_SECS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_DAYS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ZONE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DST      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HELD   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_DST_START_MONTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DST_START_DAY   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DST_END_MONTH   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DST_END_DAY     = 2'd3;

    localparam logic [MONTH_W-1:0] RST_DST_START_MONTH = 4'd3;
    localparam logic [DAY_W-1:0]   RST_DST_START_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RST_DST_END_MONTH   = 4'd10;
    localparam logic [DAY_W-1:0]   RST_DST_END_DAY     = 5'd31;

    localparam logic [YEAR_W-1:0] RST_YEAR  = 14'd1970;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]  RST_DAY   = 5'd1;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [AMT_W-1:0]  DAYS_MAX = 21'd4095;

    typedef struct packed {
        logic latch;
        logic load;
        logic reject;
        logic tod_init;
        logic day_init;
        logic div_step;
        logic split_init;
        logic hour_step;
        logic minute_step;
        logic sec_set;
        logic fwd_step;
        logic bwd_dec;
        logic bwd_add;
        logic held;
        logic commit;
        logic wd1;
        logic wd2;
        logic emit;
    } cca_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic load_ok;
        logic days_ok;
        logic zone_ok;
        logic dst_hit;
        logic tod_neg;
        logic tod_big;
        logic tod_ge_hour;
        logic tod_ge_min;
        logic fwd_need;
        logic fwd_fail;
        logic bwd_need;
        logic bwd_fail;
        logic out_free;
    } cca_status_t;

endpackage

// ----- hdl/calendar_clock_adder.sv -----
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid, s_tready  s_tdata 72 bits, s_tuser 3 bits (cmd)
// m_       out  m_tvalid, m_tready  m_tdata 48 bits, m_tuser 2 bits (status)
// cfg_     in   cfg_we              cfg_addr 2 bits, cfg_wdata 5 bits
//
// One word at a time: a valid load passes through decode, commit and the weekday states
// before its result is valid. Adding days walks the date forward one month boundary
// at a time. Adding seconds, zone changes and daylight saving reduce the time of day
// one day, hour and minute at a time, then walk the date one month boundary at a
// time, forward, or backward by stepping the month back and adding its length.
// Reset is synchronous and restores the clock to 1970-01-01 00:00:00, zone 0.
// The result waits in an output register; a new word is accepted meanwhile.
module calendar_clock_adder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // year_in, month_in, day_in, hour_in, minute_in, second_in, amount, zone_in
    input  logic [cca_pkg::IN_DATA_W-1:0]       s_tdata,
    // cmd
    input  logic [cca_pkg::CMD_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // year_out, month_out, day_out, hour_out, minute_out, second_out, zone_out, weekday
    output logic [cca_pkg::OUT_DATA_W-1:0]      m_tdata,
    // status
    output logic [cca_pkg::STATUS_W-1:0]        m_tuser,
    input  logic                                cfg_we,
    input  logic [cca_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cca_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    cca_pkg::cca_cmd_t    cmd;
    cca_pkg::cca_status_t st;

    logic [cca_pkg::YEAR_W-1:0]  out_year;
    logic [cca_pkg::MONTH_W-1:0] out_month;
    logic [cca_pkg::DAY_W-1:0]   out_day;
    logic [cca_pkg::HOUR_W-1:0]  out_hour;
    logic [cca_pkg::MIN_W-1:0]   out_minute;
    logic [cca_pkg::SEC_W-1:0]   out_second;
    logic [cca_pkg::ZONE_W-1:0]  out_zone;
    logic [cca_pkg::WDAY_W-1:0]  out_wday;

    cca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cca_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tuser),
        .in_year    (s_tdata[13:0]),
        .in_month   (s_tdata[17:14]),
        .in_day     (s_tdata[22:18]),
        .in_hour    (s_tdata[27:23]),
        .in_minute  (s_tdata[33:28]),
        .in_second  (s_tdata[39:34]),
        .in_amount  (s_tdata[60:40]),
        .in_zone    (s_tdata[65:61]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_year   (out_year),
        .out_month  (out_month),
        .out_day    (out_day),
        .out_hour   (out_hour),
        .out_minute (out_minute),
        .out_second (out_second),
        .out_zone   (out_zone),
        .out_wday   (out_wday),
        .out_status (m_tuser)
    );

    assign m_tdata = {out_wday, out_zone, out_second, out_minute,
                      out_hour, out_day, out_month, out_year};

endmodule

// ----- hdl/cca_ctrl.sv -----
module cca_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cca_pkg::cca_status_t st,
    output cca_pkg::cca_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_HOUR   = 4'd3;
    localparam logic [3:0] ST_MIN    = 4'd4;
    localparam logic [3:0] ST_FWD    = 4'd5;
    localparam logic [3:0] ST_BWD    = 4'd6;
    localparam logic [3:0] ST_BADD   = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_WD1    = 4'd9;
    localparam logic [3:0] ST_WD2    = 4'd10;
    localparam logic [3:0] ST_WD3    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (st.op)
                    cca_pkg::CMD_LOAD: begin
                        if (st.load_ok) begin
                            cmd.load   = 1'b1;
                            state_next = ST_COMMIT;
                        end else begin
                            cmd.reject = 1'b1;
                            state_next = ST_WD1;
                        end
                    end
                    cca_pkg::CMD_ADD_SECS: begin
                        cmd.tod_init = 1'b1;
                        state_next   = ST_DIV;
                    end
                    cca_pkg::CMD_ADD_DAYS: begin
                        if (st.days_ok) begin
                            cmd.day_init = 1'b1;
                            state_next   = ST_FWD;
                        end else begin
                            cmd.reject = 1'b1;
                            state_next = ST_WD1;
                        end
                    end
                    cca_pkg::CMD_ZONE: begin
                        if (st.zone_ok) begin
                            cmd.tod_init = 1'b1;
                            state_next   = ST_DIV;
                        end else begin
                            cmd.reject = 1'b1;
                            state_next = ST_WD1;
                        end
                    end
                    cca_pkg::CMD_DST: begin
                        if (st.dst_hit) begin
                            cmd.tod_init = 1'b1;
                            state_next   = ST_DIV;
                        end else begin
                            state_next = ST_WD1;
                        end
                    end
                    default: begin
                        cmd.reject = 1'b1;
                        state_next = ST_WD1;
                    end
                endcase
            end
            ST_DIV: begin
                if (st.tod_neg || st.tod_big) begin
                    cmd.div_step = 1'b1;
                end else begin
                    cmd.split_init = 1'b1;
                    state_next     = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (st.tod_ge_hour) begin
                    cmd.hour_step = 1'b1;
                end else begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                if (st.tod_ge_min) begin
                    cmd.minute_step = 1'b1;
                end else begin
                    cmd.sec_set = 1'b1;
                    state_next  = ST_FWD;
                end
            end
            ST_FWD: begin
                if (st.fwd_fail) begin
                    cmd.held   = 1'b1;
                    state_next = ST_WD1;
                end else if (st.fwd_need) begin
                    cmd.fwd_step = 1'b1;
                end else begin
                    state_next = ST_BWD;
                end
            end
            ST_BWD: begin
                if (st.bwd_fail) begin
                    cmd.held   = 1'b1;
                    state_next = ST_WD1;
                end else if (st.bwd_need) begin
                    cmd.bwd_dec = 1'b1;
                    state_next  = ST_BADD;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_BADD: begin
                cmd.bwd_add = 1'b1;
                state_next  = ST_BWD;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_WD1;
            end
            ST_WD1: begin
                cmd.wd1    = 1'b1;
                state_next = ST_WD2;
            end
            ST_WD2: begin
                cmd.wd2    = 1'b1;
                state_next = ST_WD3;
            end
            ST_WD3: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/cca_datapath.sv -----
module cca_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [cca_pkg::CMD_W-1:0]           in_cmd,
    input  logic [cca_pkg::YEAR_W-1:0]          in_year,
    input  logic [cca_pkg::MONTH_W-1:0]         in_month,
    input  logic [cca_pkg::DAY_W-1:0]           in_day,
    input  logic [cca_pkg::HOUR_W-1:0]          in_hour,
    input  logic [cca_pkg::MIN_W-1:0]           in_minute,
    input  logic [cca_pkg::SEC_W-1:0]           in_second,
    input  logic [cca_pkg::AMT_W-1:0]           in_amount,
    input  logic [cca_pkg::ZONE_W-1:0]          in_zone,
    input  logic                                cfg_we,
    input  logic [cca_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cca_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  cca_pkg::cca_cmd_t                   cmd,
    output cca_pkg::cca_status_t                st,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [cca_pkg::YEAR_W-1:0]          out_year,
    output logic [cca_pkg::MONTH_W-1:0]         out_month,
    output logic [cca_pkg::DAY_W-1:0]           out_day,
    output logic [cca_pkg::HOUR_W-1:0]          out_hour,
    output logic [cca_pkg::MIN_W-1:0]           out_minute,
    output logic [cca_pkg::SEC_W-1:0]           out_second,
    output logic [cca_pkg::ZONE_W-1:0]          out_zone,
    output logic [cca_pkg::WDAY_W-1:0]          out_wday,
    output logic [cca_pkg::STATUS_W-1:0]        out_status
);

    localparam logic [21:0] SECS_PER_DAY  = 22'd86400;
    localparam logic [21:0] SECS_PER_HOUR = 22'd3600;
    localparam logic [21:0] SECS_PER_MIN  = 22'd60;

    // The divisions by 25, 100 and 7 below use scaled reciprocals that are
    // exact over the ranges that reach them.
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [9:0]  q25;
        logic [13:0] r25;
        prod = 27'(y) * 27'd5243;
        q25  = prod[26:17];
        r25  = y - 14'(14'(q25) * 14'd25);
        return (y[1:0] == 2'b00) && ((r25 != 14'd0) || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] d;
        if (m == 4'd2) begin
            d = is_leap(y) ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            d = 5'd30;
        end else begin
            d = 5'd31;
        end
        return d;
    endfunction

    function automatic logic [5:0] zeller_month(input logic [3:0] m);
        logic [5:0] v;
        case (m)
            4'd3:    v = 6'd10;
            4'd4:    v = 6'd13;
            4'd5:    v = 6'd15;
            4'd6:    v = 6'd18;
            4'd7:    v = 6'd20;
            4'd8:    v = 6'd23;
            4'd9:    v = 6'd26;
            4'd10:   v = 6'd28;
            4'd11:   v = 6'd31;
            4'd12:   v = 6'd33;
            4'd13:   v = 6'd36;
            4'd14:   v = 6'd39;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    logic [3:0]  dst_sm_reg, dst_em_reg;
    logic [4:0]  dst_sd_reg, dst_ed_reg;

    logic [13:0] cur_year_reg, cur_year_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [4:0]  cur_day_reg, cur_day_next;
    logic [4:0]  cur_hour_reg, cur_hour_next;
    logic [5:0]  cur_minute_reg, cur_minute_next;
    logic [5:0]  cur_second_reg, cur_second_next;
    logic [4:0]  cur_zone_reg, cur_zone_next;

    logic [2:0]  in_cmd_reg, in_cmd_next;
    logic [13:0] in_year_reg, in_year_next;
    logic [3:0]  in_month_reg, in_month_next;
    logic [4:0]  in_day_reg, in_day_next;
    logic [4:0]  in_hour_reg, in_hour_next;
    logic [5:0]  in_minute_reg, in_minute_next;
    logic [5:0]  in_second_reg, in_second_next;
    logic [20:0] in_amount_reg, in_amount_next;
    logic [4:0]  in_zone_reg, in_zone_next;

    logic [13:0] w_year_reg, w_year_next;
    logic [3:0]  w_month_reg, w_month_next;
    logic [13:0] w_day_reg, w_day_next;
    logic [4:0]  w_hour_reg, w_hour_next;
    logic [5:0]  w_minute_reg, w_minute_next;
    logic [5:0]  w_second_reg, w_second_next;
    logic [4:0]  w_zone_reg, w_zone_next;
    logic [21:0] w_tod_reg, w_tod_next;
    logic [5:0]  w_dd_reg, w_dd_next;
    logic [1:0]  status_reg, status_next;

    logic [13:0] wd_y_reg, wd_y_next;
    logic [3:0]  wd_m_reg, wd_m_next;
    logic [4:0]  wd_d_reg, wd_d_next;
    logic [6:0]  wd_j_reg, wd_j_next;
    logic [9:0]  wd_sum_reg, wd_sum_next;

    logic        out_valid_reg, out_valid_next;
    logic [13:0] out_year_reg, out_year_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [4:0]  out_hour_reg, out_hour_next;
    logic [5:0]  out_minute_reg, out_minute_next;
    logic [5:0]  out_second_reg, out_second_next;
    logic [4:0]  out_zone_reg, out_zone_next;
    logic [2:0]  out_wday_reg, out_wday_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic [4:0]         dim_w;
    logic [4:0]         dim_in;
    logic [21:0]        hour_secs, min_secs, tod_now, tod_delta;
    logic [5:0]         zone_diff;
    logic signed [21:0] zone_diff_ext, zone_delta;
    logic               in_zone_ok;
    logic [13:0]        zy;
    logic [26:0]        prod_j;
    logic [6:0]         zk;
    logic [21:0]        prod_w;
    logic [7:0]         q7;

    assign dim_w  = days_in(w_year_reg, w_month_reg);
    assign dim_in = days_in(in_year_reg, in_month_reg);

    assign in_zone_ok = ($signed(in_zone_reg) >= -5'sd12) && ($signed(in_zone_reg) <= 5'sd14);

    assign hour_secs = 22'(cur_hour_reg) * SECS_PER_HOUR;
    assign min_secs  = 22'(cur_minute_reg) * SECS_PER_MIN;
    assign tod_now   = hour_secs + min_secs + 22'(cur_second_reg);

    assign zone_diff     = {in_zone_reg[4], in_zone_reg} - {cur_zone_reg[4], cur_zone_reg};
    assign zone_diff_ext = signed'({{16{zone_diff[5]}}, zone_diff});
    assign zone_delta    = zone_diff_ext * 22'sd3600;

    always_comb begin
        case (in_cmd_reg)
            cca_pkg::CMD_ADD_SECS: tod_delta = {in_amount_reg[20], in_amount_reg};
            cca_pkg::CMD_ZONE:     tod_delta = zone_delta;
            default:               tod_delta = SECS_PER_HOUR;
        endcase
    end

    assign zy     = (cur_month_reg < 4'd3) ? (cur_year_reg - 14'd1) : cur_year_reg;
    assign prod_j = 27'(zy) * 27'd5243;
    assign zk     = 7'(wd_y_reg - 14'(14'(wd_j_reg) * 14'd100));
    assign prod_w = 22'(wd_sum_reg) * 22'd2341;
    assign q7     = prod_w[21:14];

    always_comb begin
        st.op       = in_cmd_reg;
        st.load_ok  = (in_year_reg >= 14'd1) && (in_year_reg <= cca_pkg::YEAR_MAX)
                   && (in_month_reg >= 4'd1) && (in_month_reg <= 4'd12)
                   && (in_day_reg >= 5'd1) && (in_day_reg <= dim_in)
                   && (in_hour_reg <= 5'd23) && (in_minute_reg <= 6'd59)
                   && (in_second_reg <= 6'd59) && in_zone_ok;
        st.days_ok  = !in_amount_reg[20] && (in_amount_reg <= cca_pkg::DAYS_MAX);
        st.zone_ok  = in_zone_ok;
        st.dst_hit  = ((cur_month_reg > dst_sm_reg)
                       || ((cur_month_reg == dst_sm_reg) && (cur_day_reg >= dst_sd_reg)))
                   && ((cur_month_reg < dst_em_reg)
                       || ((cur_month_reg == dst_em_reg) && (cur_day_reg <= dst_ed_reg)));
        st.tod_neg     = w_tod_reg[21];
        st.tod_big     = !w_tod_reg[21] && (w_tod_reg >= SECS_PER_DAY);
        st.tod_ge_hour = w_tod_reg >= SECS_PER_HOUR;
        st.tod_ge_min  = w_tod_reg >= SECS_PER_MIN;
        st.fwd_need    = !w_day_reg[13] && (w_day_reg > 14'(dim_w));
        st.fwd_fail    = st.fwd_need && (w_month_reg == 4'd12)
                      && (w_year_reg == cca_pkg::YEAR_MAX);
        st.bwd_need    = w_day_reg[13] || (w_day_reg == 14'd0);
        st.bwd_fail    = st.bwd_need && (w_month_reg == 4'd1) && (w_year_reg == 14'd1);
        st.out_free    = !out_valid_reg || out_ready;
    end

    always_comb begin
        cur_year_next   = cur_year_reg;
        cur_month_next  = cur_month_reg;
        cur_day_next    = cur_day_reg;
        cur_hour_next   = cur_hour_reg;
        cur_minute_next = cur_minute_reg;
        cur_second_next = cur_second_reg;
        cur_zone_next   = cur_zone_reg;
        in_cmd_next     = in_cmd_reg;
        in_year_next    = in_year_reg;
        in_month_next   = in_month_reg;
        in_day_next     = in_day_reg;
        in_hour_next    = in_hour_reg;
        in_minute_next  = in_minute_reg;
        in_second_next  = in_second_reg;
        in_amount_next  = in_amount_reg;
        in_zone_next    = in_zone_reg;
        w_year_next     = w_year_reg;
        w_month_next    = w_month_reg;
        w_day_next      = w_day_reg;
        w_hour_next     = w_hour_reg;
        w_minute_next   = w_minute_reg;
        w_second_next   = w_second_reg;
        w_zone_next     = w_zone_reg;
        w_tod_next      = w_tod_reg;
        w_dd_next       = w_dd_reg;
        status_next     = status_reg;
        wd_y_next       = wd_y_reg;
        wd_m_next       = wd_m_reg;
        wd_d_next       = wd_d_reg;
        wd_j_next       = wd_j_reg;
        wd_sum_next     = wd_sum_reg;
        out_valid_next  = out_valid_reg;
        out_year_next   = out_year_reg;
        out_month_next  = out_month_reg;
        out_day_next    = out_day_reg;
        out_hour_next   = out_hour_reg;
        out_minute_next = out_minute_reg;
        out_second_next = out_second_reg;
        out_zone_next   = out_zone_reg;
        out_wday_next   = out_wday_reg;
        out_status_next = out_status_reg;

        if (cmd.latch) begin
            in_cmd_next    = in_cmd;
            in_year_next   = in_year;
            in_month_next  = in_month;
            in_day_next    = in_day;
            in_hour_next   = in_hour;
            in_minute_next = in_minute;
            in_second_next = in_second;
            in_amount_next = in_amount;
            in_zone_next   = in_zone;
            w_year_next    = cur_year_reg;
            w_month_next   = cur_month_reg;
            w_day_next     = 14'(cur_day_reg);
            w_hour_next    = cur_hour_reg;
            w_minute_next  = cur_minute_reg;
            w_second_next  = cur_second_reg;
            w_zone_next    = cur_zone_reg;
            w_dd_next      = 6'd0;
            status_next    = cca_pkg::STATUS_OK;
        end
        if (cmd.load) begin
            w_year_next   = in_year_reg;
            w_month_next  = in_month_reg;
            w_day_next    = 14'(in_day_reg);
            w_hour_next   = in_hour_reg;
            w_minute_next = in_minute_reg;
            w_second_next = in_second_reg;
            w_zone_next   = in_zone_reg;
        end
        if (cmd.reject) begin
            status_next = cca_pkg::STATUS_REJECT;
        end
        if (cmd.held) begin
            status_next = cca_pkg::STATUS_HELD;
        end
        if (cmd.tod_init) begin
            w_tod_next = tod_now + tod_delta;
            if (in_cmd_reg == cca_pkg::CMD_ZONE) begin
                w_zone_next = in_zone_reg;
            end
        end
        if (cmd.day_init) begin
            w_day_next = 14'(cur_day_reg) + in_amount_reg[13:0];
        end
        if (cmd.div_step) begin
            if (w_tod_reg[21]) begin
                w_tod_next = w_tod_reg + SECS_PER_DAY;
                w_dd_next  = w_dd_reg - 6'd1;
            end else begin
                w_tod_next = w_tod_reg - SECS_PER_DAY;
                w_dd_next  = w_dd_reg + 6'd1;
            end
        end
        if (cmd.split_init) begin
            w_day_next    = 14'(cur_day_reg) + {{8{w_dd_reg[5]}}, w_dd_reg};
            w_hour_next   = 5'd0;
            w_minute_next = 6'd0;
        end
        if (cmd.hour_step) begin
            w_tod_next  = w_tod_reg - SECS_PER_HOUR;
            w_hour_next = w_hour_reg + 5'd1;
        end
        if (cmd.minute_step) begin
            w_tod_next    = w_tod_reg - SECS_PER_MIN;
            w_minute_next = w_minute_reg + 6'd1;
        end
        if (cmd.sec_set) begin
            w_second_next = w_tod_reg[5:0];
        end
        if (cmd.fwd_step) begin
            w_day_next = w_day_reg - 14'(dim_w);
            if (w_month_reg == 4'd12) begin
                w_month_next = 4'd1;
                w_year_next  = w_year_reg + 14'd1;
            end else begin
                w_month_next = w_month_reg + 4'd1;
            end
        end
        if (cmd.bwd_dec) begin
            if (w_month_reg == 4'd1) begin
                w_month_next = 4'd12;
                w_year_next  = w_year_reg - 14'd1;
            end else begin
                w_month_next = w_month_reg - 4'd1;
            end
        end
        if (cmd.bwd_add) begin
            w_day_next = w_day_reg + 14'(dim_w);
        end
        if (cmd.commit) begin
            cur_year_next   = w_year_reg;
            cur_month_next  = w_month_reg;
            cur_day_next    = w_day_reg[4:0];
            cur_hour_next   = w_hour_reg;
            cur_minute_next = w_minute_reg;
            cur_second_next = w_second_reg;
            cur_zone_next   = w_zone_reg;
        end
        if (cmd.wd1) begin
            wd_y_next = zy;
            wd_m_next = (cur_month_reg < 4'd3) ? (cur_month_reg + 4'd12) : cur_month_reg;
            wd_d_next = cur_day_reg;
            wd_j_next = prod_j[25:19];
        end
        if (cmd.wd2) begin
            wd_sum_next = 10'(wd_d_reg) + 10'(zeller_month(wd_m_reg)) + 10'(zk)
                        + 10'(zk[6:2]) + 10'(wd_j_reg[6:2]) + 10'(wd_j_reg) * 10'd5;
        end
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next  = 1'b1;
            out_year_next   = cur_year_reg;
            out_month_next  = cur_month_reg;
            out_day_next    = cur_day_reg;
            out_hour_next   = cur_hour_reg;
            out_minute_next = cur_minute_reg;
            out_second_next = cur_second_reg;
            out_zone_next   = cur_zone_reg;
            out_wday_next   = 3'(wd_sum_reg - 10'(10'(q7) * 10'd7));
            out_status_next = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_sm_reg     <= cca_pkg::RST_DST_START_MONTH;
            dst_sd_reg     <= cca_pkg::RST_DST_START_DAY;
            dst_em_reg     <= cca_pkg::RST_DST_END_MONTH;
            dst_ed_reg     <= cca_pkg::RST_DST_END_DAY;
            cur_year_reg   <= cca_pkg::RST_YEAR;
            cur_month_reg  <= cca_pkg::RST_MONTH;
            cur_day_reg    <= cca_pkg::RST_DAY;
            cur_hour_reg   <= 5'd0;
            cur_minute_reg <= 6'd0;
            cur_second_reg <= 6'd0;
            cur_zone_reg   <= 5'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    cca_pkg::CFG_DST_START_MONTH: dst_sm_reg <= cfg_wdata[3:0];
                    cca_pkg::CFG_DST_START_DAY:   dst_sd_reg <= cfg_wdata;
                    cca_pkg::CFG_DST_END_MONTH:   dst_em_reg <= cfg_wdata[3:0];
                    cca_pkg::CFG_DST_END_DAY:     dst_ed_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            cur_year_reg   <= cur_year_next;
            cur_month_reg  <= cur_month_next;
            cur_day_reg    <= cur_day_next;
            cur_hour_reg   <= cur_hour_next;
            cur_minute_reg <= cur_minute_next;
            cur_second_reg <= cur_second_next;
            cur_zone_reg   <= cur_zone_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_cmd_reg     <= in_cmd_next;
        in_year_reg    <= in_year_next;
        in_month_reg   <= in_month_next;
        in_day_reg     <= in_day_next;
        in_hour_reg    <= in_hour_next;
        in_minute_reg  <= in_minute_next;
        in_second_reg  <= in_second_next;
        in_amount_reg  <= in_amount_next;
        in_zone_reg    <= in_zone_next;
        w_year_reg     <= w_year_next;
        w_month_reg    <= w_month_next;
        w_day_reg      <= w_day_next;
        w_hour_reg     <= w_hour_next;
        w_minute_reg   <= w_minute_next;
        w_second_reg   <= w_second_next;
        w_zone_reg     <= w_zone_next;
        w_tod_reg      <= w_tod_next;
        w_dd_reg       <= w_dd_next;
        status_reg     <= status_next;
        wd_y_reg       <= wd_y_next;
        wd_m_reg       <= wd_m_next;
        wd_d_reg       <= wd_d_next;
        wd_j_reg       <= wd_j_next;
        wd_sum_reg     <= wd_sum_next;
        out_year_reg   <= out_year_next;
        out_month_reg  <= out_month_next;
        out_day_reg    <= out_day_next;
        out_hour_reg   <= out_hour_next;
        out_minute_reg <= out_minute_next;
        out_second_reg <= out_second_next;
        out_zone_reg   <= out_zone_next;
        out_wday_reg   <= out_wday_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_year   = out_year_reg;
    assign out_month  = out_month_reg;
    assign out_day    = out_day_reg;
    assign out_hour   = out_hour_reg;
    assign out_minute = out_minute_reg;
    assign out_second = out_second_reg;
    assign out_zone   = out_zone_reg;
    assign out_wday   = out_wday_reg;
    assign out_status = out_status_reg;

    a_commit_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (status_reg == cca_pkg::STATUS_OK))
        else $error("commit of a rejected or held word");

    a_date_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12) && (cur_day_reg >= 5'd1)
        && (cur_day_reg <= days_in(cur_year_reg, cur_month_reg)))
        else $error("current date out of range");

    a_clock_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_hour_reg <= 5'd23) && (cur_minute_reg <= 6'd59) && (cur_second_reg <= 6'd59))
        else $error("current time of day out of range");

    a_split_in_day: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.split_init |-> (!w_tod_reg[21] && (w_tod_reg < SECS_PER_DAY)))
        else $error("seconds remainder not within one day");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a word still waiting");

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ZONE_LO = -12;
    localparam int ZONE_HI = 14;
    localparam int SECS_DAY = 86400;
    localparam logic [cca_pkg::CMD_W-1:0] CMD_BAD = 3'd7;

    typedef struct {
        logic [cca_pkg::CMD_W-1:0]          cmd;
        logic [cca_pkg::YEAR_W-1:0]         year;
        logic [cca_pkg::MONTH_W-1:0]        month;
        logic [cca_pkg::DAY_W-1:0]          day;
        logic [cca_pkg::HOUR_W-1:0]         hour;
        logic [cca_pkg::MIN_W-1:0]          minute;
        logic [cca_pkg::SEC_W-1:0]          second;
        logic signed [cca_pkg::AMT_W-1:0]   amount;
        logic signed [cca_pkg::ZONE_W-1:0]  zone;
    } clock_word_t;

    typedef struct {
        logic [cca_pkg::YEAR_W-1:0]   year;
        logic [cca_pkg::MONTH_W-1:0]  month;
        logic [cca_pkg::DAY_W-1:0]    day;
        logic [cca_pkg::HOUR_W-1:0]   hour;
        logic [cca_pkg::MIN_W-1:0]    minute;
        logic [cca_pkg::SEC_W-1:0]    second;
        logic [cca_pkg::ZONE_W-1:0]   zone;
        logic [cca_pkg::WDAY_W-1:0]   weekday;
        logic [cca_pkg::STATUS_W-1:0] status;
    } clock_reading_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cca_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [cca_pkg::CMD_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cca_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [cca_pkg::STATUS_W-1:0]   m_tuser;
    logic                           cfg_we;
    logic [cca_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [cca_pkg::CFG_DATA_W-1:0] cfg_wdata;

    calendar_clock_adder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted clock state and daylight-saving window.
    int now_year, now_month, now_day, now_hour, now_minute, now_second, now_zone;
    int win_start_month, win_start_day, win_end_month, win_end_day;

    clock_reading_t expected_readings[$];
    int  errors;
    int  words_sent;
    int  readings_seen;
    int  cfg_writes;
    int  status_tally[4];
    bit  calm_mode;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d readings still pending.", expected_readings.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit leap_year(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_days(int y, int m);
        int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) return 31;
        if (m == 2 && leap_year(y)) return 29;
        return lens[m-1];
    endfunction

    function automatic bit move_date(longint delta);
        longint y, m, d;
        y = now_year;
        m = now_month;
        d = now_day + delta;
        while (d > month_days(int'(y), int'(m))) begin
            d -= month_days(int'(y), int'(m));
            m++;
            if (m > 12) begin
                m = 1;
                y++;
                if (y > int'(cca_pkg::YEAR_MAX)) return 1'b0;
            end
        end
        while (d < 1) begin
            m--;
            if (m < 1) begin
                m = 12;
                y--;
                if (y < 1) return 1'b0;
            end
            d += month_days(int'(y), int'(m));
        end
        now_year  = int'(y);
        now_month = int'(m);
        now_day   = int'(d);
        return 1'b1;
    endfunction

    function automatic logic [cca_pkg::STATUS_W-1:0] add_seconds(longint amt);
        longint t, dd, rem;
        t = longint'(now_hour) * 3600 + longint'(now_minute) * 60 + longint'(now_second) + amt;
        if (t >= 0) dd = t / SECS_DAY;
        else dd = -((-t + SECS_DAY - 1) / SECS_DAY);
        rem = t - dd * SECS_DAY;
        if (!move_date(dd)) return cca_pkg::STATUS_HELD;
        now_hour   = int'(rem / 3600);
        now_minute = int'((rem / 60) % 60);
        now_second = int'(rem % 60);
        return cca_pkg::STATUS_OK;
    endfunction

    function automatic int zeller_weekday(int y, int m, int d);
        int k, j;
        if (m < 3) begin
            m += 12;
            y -= 1;
        end
        k = y % 100;
        j = y / 100;
        return (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    endfunction

    function automatic clock_reading_t apply_word(clock_word_t w);
        clock_reading_t r;
        int yi, mi, di, hi, ni, si, zi, wd;
        longint amt;
        logic [cca_pkg::STATUS_W-1:0] st;
        bit zone_ok;
        yi = int'(w.year);
        mi = int'(w.month);
        di = int'(w.day);
        hi = int'(w.hour);
        ni = int'(w.minute);
        si = int'(w.second);
        zi = int'(w.zone);
        amt = longint'(w.amount);
        st = cca_pkg::STATUS_OK;
        zone_ok = zi >= ZONE_LO && zi <= ZONE_HI;
        case (w.cmd)
            cca_pkg::CMD_LOAD: begin
                if (yi < 1 || yi > int'(cca_pkg::YEAR_MAX) || mi < 1 || mi > 12 ||
                    di < 1 || di > month_days(yi, mi) || hi > 23 || ni > 59 ||
                    si > 59 || !zone_ok) begin
                    st = cca_pkg::STATUS_REJECT;
                end else begin
                    now_year   = yi;
                    now_month  = mi;
                    now_day    = di;
                    now_hour   = hi;
                    now_minute = ni;
                    now_second = si;
                    now_zone   = zi;
                end
            end
            cca_pkg::CMD_ADD_SECS: st = add_seconds(amt);
            cca_pkg::CMD_ADD_DAYS: begin
                if (amt < 0 || amt > int'(cca_pkg::DAYS_MAX)) st = cca_pkg::STATUS_REJECT;
                else if (!move_date(amt)) st = cca_pkg::STATUS_HELD;
            end
            cca_pkg::CMD_ZONE: begin
                if (!zone_ok) begin
                    st = cca_pkg::STATUS_REJECT;
                end else begin
                    st = add_seconds(longint'(zi - now_zone) * 3600);
                    if (st == cca_pkg::STATUS_OK) now_zone = zi;
                end
            end
            cca_pkg::CMD_DST: begin
                if ((now_month > win_start_month ||
                     (now_month == win_start_month && now_day >= win_start_day)) &&
                    (now_month < win_end_month ||
                     (now_month == win_end_month && now_day <= win_end_day)))
                    st = add_seconds(3600);
            end
            default: st = cca_pkg::STATUS_REJECT;
        endcase
        wd = zeller_weekday(now_year, now_month, now_day);
        r.year    = now_year[cca_pkg::YEAR_W-1:0];
        r.month   = now_month[cca_pkg::MONTH_W-1:0];
        r.day     = now_day[cca_pkg::DAY_W-1:0];
        r.hour    = now_hour[cca_pkg::HOUR_W-1:0];
        r.minute  = now_minute[cca_pkg::MIN_W-1:0];
        r.second  = now_second[cca_pkg::SEC_W-1:0];
        r.zone    = now_zone[cca_pkg::ZONE_W-1:0];
        r.weekday = wd[cca_pkg::WDAY_W-1:0];
        r.status  = st;
        return r;
    endfunction

    function automatic clock_word_t make_load(int y, int mo, int d, int h, int mi, int s, int z);
        clock_word_t w;
        int a;
        a = $urandom;
        w.cmd    = cca_pkg::CMD_LOAD;
        w.year   = y[cca_pkg::YEAR_W-1:0];
        w.month  = mo[cca_pkg::MONTH_W-1:0];
        w.day    = d[cca_pkg::DAY_W-1:0];
        w.hour   = h[cca_pkg::HOUR_W-1:0];
        w.minute = mi[cca_pkg::MIN_W-1:0];
        w.second = s[cca_pkg::SEC_W-1:0];
        w.amount = a[cca_pkg::AMT_W-1:0];
        w.zone   = z[cca_pkg::ZONE_W-1:0];
        return w;
    endfunction

    function automatic clock_word_t make_op(logic [cca_pkg::CMD_W-1:0] cmd, int amt, int z);
        clock_word_t w;
        int a;
        a = $urandom;
        w = make_load(a[13:0], a[17:14], a[22:18], a[27:23], $urandom, $urandom, z);
        w.cmd    = cmd;
        w.amount = amt[cca_pkg::AMT_W-1:0];
        return w;
    endfunction

    function automatic clock_word_t random_word();
        clock_word_t w;
        int pick, y, mo, k;
        w = make_op(cca_pkg::CMD_DST, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    w = make_load(int'(cca_pkg::YEAR_MAX), 12, $urandom_range(25, 31),
                                  $urandom_range(0, 23), $urandom_range(0, 59),
                                  $urandom_range(0, 59), $urandom_range(0, 26) + ZONE_LO);
                else
                    w = make_load(1, 1, $urandom_range(1, 6), $urandom_range(0, 23),
                                  $urandom_range(0, 59), $urandom_range(0, 59),
                                  $urandom_range(0, 26) + ZONE_LO);
            end else begin
                y  = $urandom_range(1, int'(cca_pkg::YEAR_MAX));
                mo = $urandom_range(1, 12);
                w = make_load(y, mo, $urandom_range(1, month_days(y, mo)), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 59),
                              $urandom_range(0, 26) + ZONE_LO);
            end
        end else if (pick < 45) begin
            w.cmd = cca_pkg::CMD_ADD_SECS;
            case ($urandom_range(0, 3))
                0: k = $urandom;
                1: k = $urandom_range(0, 200000) - 100000;
                2: k = ($urandom_range(0, 24) - 12) * SECS_DAY + $urandom_range(0, 2) - 1;
                default: k = $urandom_range(0, 60) - 30;
            endcase
            w.amount = k[cca_pkg::AMT_W-1:0];
        end else if (pick < 60) begin
            w.cmd = cca_pkg::CMD_ADD_DAYS;
            case ($urandom_range(0, 19))
                0: k = $urandom;
                1, 2: k = $urandom_range(0, int'(cca_pkg::DAYS_MAX));
                default: k = $urandom_range(0, 400);
            endcase
            w.amount = k[cca_pkg::AMT_W-1:0];
        end else if (pick < 75) begin
            w.cmd = cca_pkg::CMD_ZONE;
            k = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 26) + ZONE_LO;
            w.zone = k[cca_pkg::ZONE_W-1:0];
        end else if (pick >= 90) begin
            k = $urandom_range(0, 7);
            w.cmd = k[cca_pkg::CMD_W-1:0];
        end
        return w;
    endfunction

    task automatic send_word(clock_word_t w);
        int gap;
        gap = calm_mode ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= {6'd0, w.zone, w.amount, w.second, w.minute, w.hour, w.day, w.month, w.year};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_readings.push_back(apply_word(w));
        words_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [cca_pkg::CFG_ADDR_W-1:0] addr, int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[cca_pkg::CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            cca_pkg::CFG_DST_START_MONTH: win_start_month = value & 15;
            cca_pkg::CFG_DST_START_DAY:   win_start_day   = value & 31;
            cca_pkg::CFG_DST_END_MONTH:   win_end_month   = value & 15;
            default:                      win_end_day     = value & 31;
        endcase
        cfg_writes++;
    endtask

    task automatic set_window(int sm, int sd, int em, int ed);
        wait_idle();
        write_reg(cca_pkg::CFG_DST_START_MONTH, sm);
        write_reg(cca_pkg::CFG_DST_START_DAY, sd);
        write_reg(cca_pkg::CFG_DST_END_MONTH, em);
        write_reg(cca_pkg::CFG_DST_END_DAY, ed);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial begin : result_side
        int stall;
        clock_reading_t want;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = calm_mode ? 0 : $urandom_range(0, 15);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            readings_seen++;
            status_tally[m_tuser]++;
            if (expected_readings.size() == 0) begin
                $error("result word with no expectation pending");
                errors++;
            end else begin
                want = expected_readings.pop_front();
                check_field("year_out", want.year, m_tdata[13:0]);
                check_field("month_out", want.month, m_tdata[17:14]);
                check_field("day_out", want.day, m_tdata[22:18]);
                check_field("hour_out", want.hour, m_tdata[27:23]);
                check_field("minute_out", want.minute, m_tdata[33:28]);
                check_field("second_out", want.second, m_tdata[39:34]);
                check_field("zone_out", int'($signed(want.zone)), int'($signed(m_tdata[44:40])));
                check_field("weekday", want.weekday, m_tdata[47:45]);
                check_field("status", want.status, m_tuser);
            end
        end
    end

    task automatic test_reset_state();
        // 1970-01-01 lies before the default window, so nothing moves.
        send_word(make_op(cca_pkg::CMD_DST, 0, 0));
    endtask

    task automatic test_loads();
        send_word(make_load(1900, 2, 29, 0, 0, 0, 0));
        send_word(make_load(2024, 2, 29, 23, 59, 59, ZONE_HI));
        send_word(make_op(cca_pkg::CMD_ADD_SECS, 1, 0));
        send_word(make_load(0, 13, 0, 0, 0, 0, 0));
        send_word(make_load(2000, 4, 30, 24, 60, 63, 0));
        send_word(make_load(2000, 2, 29, 0, 0, 0, 15));
        send_word(make_load(2000, 2, 29, 0, 0, 0, ZONE_LO));
    endtask

    task automatic test_seconds();
        send_word(make_op(cca_pkg::CMD_ADD_SECS, -1048576, 0));
        send_word(make_op(cca_pkg::CMD_ADD_SECS, 1048575, 0));
    endtask

    task automatic test_days();
        send_word(make_op(cca_pkg::CMD_ADD_DAYS, int'(cca_pkg::DAYS_MAX), 0));
        send_word(make_op(cca_pkg::CMD_ADD_DAYS, -1, 0));
        send_word(make_op(cca_pkg::CMD_ADD_DAYS, int'(cca_pkg::DAYS_MAX) + 1, 0));
    endtask

    task automatic test_zone();
        send_word(make_op(cca_pkg::CMD_ZONE, 0, ZONE_HI));
        send_word(make_op(cca_pkg::CMD_ZONE, 0, -16));
        send_word(make_op(CMD_BAD, 0, 0));
    endtask

    task automatic test_year_limits();
        send_word(make_load(int'(cca_pkg::YEAR_MAX), 12, 31, 23, 59, 59, 0));
        send_word(make_op(cca_pkg::CMD_ADD_SECS, 1, 0));
        send_word(make_op(cca_pkg::CMD_ADD_DAYS, 1, 0));
        send_word(make_op(cca_pkg::CMD_ZONE, 0, ZONE_HI));
        send_word(make_load(1, 1, 1, 0, 0, 0, ZONE_HI));
        send_word(make_op(cca_pkg::CMD_ZONE, 0, ZONE_LO));
        send_word(make_op(cca_pkg::CMD_ADD_SECS, -1, 0));
    endtask

    task automatic test_dst_window();
        set_window(3, 10, 11, 3);
        send_word(make_load(2023, 3, 10, 8, 0, 0, 0));
        send_word(make_op(cca_pkg::CMD_DST, 0, 0));
        send_word(make_load(2023, 11, 4, 8, 0, 0, 0));
        send_word(make_op(cca_pkg::CMD_DST, 0, 0));
    endtask

    task automatic test_random(int count);
        repeat (count) send_word(random_word());
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        calm_mode = 1'b0;
        errors = 0;
        words_sent = 0;
        readings_seen = 0;
        cfg_writes = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
        now_year = int'(cca_pkg::RST_YEAR);
        now_month = int'(cca_pkg::RST_MONTH);
        now_day = int'(cca_pkg::RST_DAY);
        now_hour = 0;
        now_minute = 0;
        now_second = 0;
        now_zone = 0;
        win_start_month = int'(cca_pkg::RST_DST_START_MONTH);
        win_start_day   = int'(cca_pkg::RST_DST_START_DAY);
        win_end_month   = int'(cca_pkg::RST_DST_END_MONTH);
        win_end_day     = int'(cca_pkg::RST_DST_END_DAY);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_loads();
        test_seconds();
        test_days();
        test_zone();
        test_year_limits();
        test_dst_window();

        set_window(int'(cca_pkg::RST_DST_START_MONTH), int'(cca_pkg::RST_DST_START_DAY),
                   int'(cca_pkg::RST_DST_END_MONTH), int'(cca_pkg::RST_DST_END_DAY));
        test_random(100);
        set_window(1, 1, 12, 31);
        test_random(80);
        set_window(15, 0, 0, 0);
        test_random(60);
        set_window(2, 29, 2, 29);
        calm_mode = 1'b1;
        test_random(60);
        calm_mode = 1'b0;
        set_window(12, 31, 12, 31);
        test_random(100);

        wait_idle();
        repeat (150) @(posedge aclk);
        $display("Sent %0d words, checked %0d results, %0d register writes.",
                 words_sent, readings_seen, cfg_writes);
        $display("Status mix: ok %0d, rejected %0d, held %0d.",
                 status_tally[0], status_tally[1], status_tally[2]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
